@@ rtl/rmq_pkg.sv @@
// Shared constants and types for the rotation-matrix-to-quaternion converter.
`timescale 1ns / 1ps

package rmq_pkg;

    // Default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 14;

    // Width of one matrix element and of one quaternion component
    localparam int ELEM_W = 16;

    // Number of matrix elements in one input transfer
    localparam int N_ELEM = 9;

    // Width of an off-diagonal sum or difference
    localparam int OD_W = ELEM_W + 2;

    // Number of off-diagonal sums and differences
    localparam int N_OD = 6;

    // Chosen candidate
    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_S = 2'd3
    } branch_t;

    // Positions of the off-diagonal terms in the packed side data
    localparam int OD_S01 = 0;  // m01 + m10
    localparam int OD_S02 = 1;  // m02 + m20
    localparam int OD_S12 = 2;  // m12 + m21
    localparam int OD_D12 = 3;  // m12 - m21
    localparam int OD_D20 = 4;  // m20 - m02
    localparam int OD_D01 = 5;  // m01 - m10

endpackage

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// Top level: direction cosine matrix to normalised quaternion converter.
`timescale 1ns / 1ps

// Converts one 3x3 direction cosine matrix (nine signed fixed-point elements with
// FRAC_BITS fraction bits) into a unit quaternion, scalar part first, by picking
// the largest of four square-root candidates. One matrix is taken every clock
// cycle. A matrix passes in turn through the bit-per-stage candidate root, the
// off-diagonal divider, the norm root and the normalising divider.
// Every stage advances together: while a result waits unaccepted on the output
// the whole pipeline holds and no transfer is taken at the input. A zero
// candidate or zero norm returns all-zero components with the degenerate flag
// set; branch_taken still reports the chosen candidate.
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [N_ELEM*ELEM_W-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // q_scalar, q_x, q_y, q_z (16 bits each)
    output logic [4*ELEM_W-1:0]     m_axis_tdata,
    // branch_taken (2 bits), degenerate (1 bit)
    output logic [2:0]              m_axis_tuser
);

    // Candidate root argument and root widths
    localparam int NW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int XW1 = NW - 1 + FRAC_BITS;
    localparam int XE1 = XW1 + (XW1 % 2);
    localparam int RW1 = XE1 / 2;
    localparam int CW  = RW1 - 1;

    // Off-diagonal division widths
    localparam int MAG_W = OD_W - 1;
    localparam int N1_W  = MAG_W + FRAC_BITS;
    localparam int D1_W  = CW + 2;
    localparam int Q1_W  = FRAC_BITS + 15;
    localparam int QX0   = (Q1_W > CW) ? Q1_W : CW;
    localparam int QX    = (QX0 > 31) ? QX0 : 31;

    // Norm and normalisation widths
    localparam int QC_W = 32;
    localparam int QA_W = 31;
    localparam int SQ_W = 2 * QA_W;
    localparam int SS_W = 64;
    localparam int RW2  = SS_W / 2;
    localparam int N2_W = QA_W + FRAC_BITS;
    localparam int Q2_W = FRAC_BITS + 1;
    localparam int QY   = ((Q2_W > ELEM_W + 1) ? Q2_W : ELEM_W + 1) + 1;

    // Side data widths
    localparam int P1_W = N_OD * OD_W;
    localparam int P3_W = CW + 2 + 4 + 1;
    localparam int P7_W = 4 * QC_W + 2;
    localparam int P8_W = 1 + 4 + 2;

    localparam logic [NW-1:0] ONE = NW'(1) << FRAC_BITS;
    localparam logic [QX-1:0] LIM = QX'(1) << 30;

    logic ce;

    // Hold everything while a finished result waits
    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    // ------------------------------------------------------------------
    // Stage 1: root arguments and off-diagonal terms
    // ------------------------------------------------------------------
    logic signed [ELEM_W-1:0] m [N_ELEM];
    logic [XE1-1:0]           x1_next [4];
    logic [P1_W-1:0]          od1_next;

    logic [XE1-1:0]           x1_reg [4];
    logic [P1_W-1:0]          od1_reg;
    logic                     v1_reg;

    always_comb
    begin
        logic signed [NW-1:0]   tr;
        logic signed [NW-1:0]   num4 [4];
        logic signed [OD_W-1:0] od [N_OD];
        for (int i = 0; i < N_ELEM; i++)
        begin
            m[i] = signed'(s_axis_tdata[i*ELEM_W +: ELEM_W]);
        end
        tr = NW'(m[0]) + NW'(m[4]) + NW'(m[8]);
        num4[0] = signed'(ONE) + (NW'(m[0]) <<< 1) - tr;
        num4[1] = signed'(ONE) + (NW'(m[4]) <<< 1) - tr;
        num4[2] = signed'(ONE) + (NW'(m[8]) <<< 1) - tr;
        num4[3] = signed'(ONE) + tr;
        // Clamp negative arguments to zero
        for (int i = 0; i < 4; i++)
        begin
            if (!num4[i][NW-1] && (num4[i] != '0))
            begin
                x1_next[i] = XE1'(num4[i][NW-2:0]) << FRAC_BITS;
            end
            else
            begin
                x1_next[i] = '0;
            end
        end
        od[OD_S01] = OD_W'(m[1]) + OD_W'(m[3]);
        od[OD_S02] = OD_W'(m[2]) + OD_W'(m[6]);
        od[OD_S12] = OD_W'(m[5]) + OD_W'(m[7]);
        od[OD_D12] = OD_W'(m[5]) - OD_W'(m[7]);
        od[OD_D20] = OD_W'(m[6]) - OD_W'(m[2]);
        od[OD_D01] = OD_W'(m[1]) - OD_W'(m[3]);
        for (int i = 0; i < N_OD; i++)
        begin
            od1_next[i*OD_W +: OD_W] = od[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x1_reg  <= x1_next;
            od1_reg <= od1_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    // ------------------------------------------------------------------
    // Candidate roots
    // ------------------------------------------------------------------
    logic             v2;
    logic [RW1-1:0]   root1 [4];
    logic [P1_W-1:0]  od2;

    rmq_sqrt_pipe #(
        .XW    (XE1),
        .LANES (4),
        .PW    (P1_W)
    ) u_cand_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v1_reg),
        .x         (x1_reg),
        .in_pay    (od1_reg),
        .out_valid (v2),
        .root      (root1),
        .out_pay   (od2)
    );

    // ------------------------------------------------------------------
    // Stage 3: pick the branch and set up the off-diagonal quotients
    // ------------------------------------------------------------------
    logic [N1_W-1:0]  num3_next [4];
    logic [D1_W-1:0]  den3_next;
    logic [P3_W-1:0]  pay3_next;

    logic [N1_W-1:0]  num3_reg [4];
    logic [D1_W-1:0]  den3_reg;
    logic [P3_W-1:0]  pay3_reg;
    logic             v3_reg;

    always_comb
    begin
        logic [CW-1:0]          c [4];
        logic [CW-1:0]          b;
        branch_t                br;
        logic signed [OD_W-1:0] od [N_OD];
        logic signed [OD_W-1:0] n [4];
        logic [3:0]             neg;
        logic [MAG_W-1:0]       mag;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = root1[i][RW1-1:1];
        end
        for (int i = 0; i < N_OD; i++)
        begin
            od[i] = signed'(od2[i*OD_W +: OD_W]);
        end
        // Strictly largest wins; ties fall to the scalar candidate
        if ((c[0] > c[1]) && (c[0] > c[2]) && (c[0] > c[3]))
        begin
            br = BR_X;
            b  = c[0];
        end
        else if ((c[1] > c[0]) && (c[1] > c[2]) && (c[1] > c[3]))
        begin
            br = BR_Y;
            b  = c[1];
        end
        else if ((c[2] > c[0]) && (c[2] > c[1]) && (c[2] > c[3]))
        begin
            br = BR_Z;
            b  = c[2];
        end
        else
        begin
            br = BR_S;
            b  = c[3];
        end
        // Numerators in scalar, x, y, z order; the chosen lane is unused
        case (br)
            BR_X:
            begin
                n[0] = od[OD_D12];
                n[1] = '0;
                n[2] = od[OD_S01];
                n[3] = od[OD_S02];
            end
            BR_Y:
            begin
                n[0] = od[OD_D20];
                n[1] = od[OD_S01];
                n[2] = '0;
                n[3] = od[OD_S12];
            end
            BR_Z:
            begin
                n[0] = od[OD_D01];
                n[1] = od[OD_S02];
                n[2] = od[OD_S12];
                n[3] = '0;
            end
            default:
            begin
                n[0] = '0;
                n[1] = od[OD_D12];
                n[2] = od[OD_D20];
                n[3] = od[OD_D01];
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            neg[i]       = n[i][OD_W-1];
            mag          = neg[i] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
            num3_next[i] = N1_W'(mag) << FRAC_BITS;
        end
        den3_next = {b, 2'b00};
        pay3_next = {(b == '0), neg, br, b};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num3_reg <= num3_next;
            den3_reg <= den3_next;
            pay3_reg <= pay3_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v3_reg <= v2;
        end
    end

    // ------------------------------------------------------------------
    // Off-diagonal quotients
    // ------------------------------------------------------------------
    logic             v4;
    logic [Q1_W-1:0]  quo1 [4];
    logic [P3_W-1:0]  pay4;

    rmq_div_pipe #(
        .NUM_W (N1_W),
        .DEN_W (D1_W),
        .QW    (Q1_W),
        .LANES (4),
        .PW    (P3_W)
    ) u_od_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .num       (num3_reg),
        .den       (den3_reg),
        .in_pay    (pay3_reg),
        .out_valid (v4),
        .quo       (quo1),
        .out_pay   (pay4)
    );

    // ------------------------------------------------------------------
    // Stage 4: place the candidate, apply signs, clamp growth
    // ------------------------------------------------------------------
    logic signed [QC_W-1:0] qc4_next [4];
    logic signed [QC_W-1:0] qc4_reg [4];
    branch_t                br4_reg;
    logic                   v4_reg;

    always_comb
    begin
        logic [CW-1:0] b;
        branch_t       br;
        logic [3:0]    neg;
        logic          bz;
        logic [3:0]    is_b;
        logic [QX-1:0] mag;
        logic [QX-1:0] clp;
        b   = pay4[CW-1:0];
        br  = branch_t'(pay4[CW +: 2]);
        neg = pay4[CW+2 +: 4];
        bz  = pay4[CW+6];
        is_b[0] = (br == BR_S);
        is_b[1] = (br == BR_X);
        is_b[2] = (br == BR_Y);
        is_b[3] = (br == BR_Z);
        for (int i = 0; i < 4; i++)
        begin
            mag = is_b[i] ? QX'(b) : QX'(quo1[i]);
            clp = (mag > LIM) ? LIM : mag;
            if (bz)
            begin
                qc4_next[i] = '0;
            end
            else if (neg[i] && !is_b[i])
            begin
                qc4_next[i] = -signed'(QC_W'(clp));
            end
            else
            begin
                qc4_next[i] = signed'(QC_W'(clp));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            qc4_reg <= qc4_next;
            br4_reg <= branch_t'(pay4[CW +: 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ce)
        begin
            v4_reg <= v4;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 7: squares, pair sums, total
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]        sq5_reg [4];
    logic signed [QC_W-1:0] qc5_reg [4];
    branch_t                br5_reg;
    logic                   v5_reg;

    logic [SQ_W:0]          p6_reg [2];
    logic signed [QC_W-1:0] qc6_reg [4];
    branch_t                br6_reg;
    logic                   v6_reg;

    logic [SS_W-1:0]        ss7_reg [1];
    logic [P7_W-1:0]        pay7_reg;
    logic                   v7_reg;

    logic [QA_W-1:0]        a5 [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a5[i] = qc4_reg[i][QC_W-1] ? QA_W'(-qc4_reg[i]) : QA_W'(qc4_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq5_reg[i] <= SQ_W'(a5[i]) * SQ_W'(a5[i]);
            end
            qc5_reg <= qc4_reg;
            br5_reg <= br4_reg;

            p6_reg[0] <= (SQ_W+1)'(sq5_reg[0]) + (SQ_W+1)'(sq5_reg[1]);
            p6_reg[1] <= (SQ_W+1)'(sq5_reg[2]) + (SQ_W+1)'(sq5_reg[3]);
            qc6_reg   <= qc5_reg;
            br6_reg   <= br5_reg;

            ss7_reg[0] <= SS_W'(p6_reg[0]) + SS_W'(p6_reg[1]);
            pay7_reg   <= {br6_reg, qc6_reg[3], qc6_reg[2], qc6_reg[1], qc6_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (ce)
        begin
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Norm root
    // ------------------------------------------------------------------
    logic             v8;
    logic [RW2-1:0]   nrm [1];
    logic [P7_W-1:0]  pay8;

    rmq_sqrt_pipe #(
        .XW    (SS_W),
        .LANES (1),
        .PW    (P7_W)
    ) u_norm_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v7_reg),
        .x         (ss7_reg),
        .in_pay    (pay7_reg),
        .out_valid (v8),
        .root      (nrm),
        .out_pay   (pay8)
    );

    // ------------------------------------------------------------------
    // Stage 8: set up the normalising division
    // ------------------------------------------------------------------
    logic [N2_W-1:0]  num8_next [4];
    logic [P8_W-1:0]  pay8_next;

    logic [N2_W-1:0]  num8_reg [4];
    logic [RW2-1:0]   den8_reg;
    logic [P8_W-1:0]  pay8_reg;
    logic             v8_reg;

    always_comb
    begin
        logic signed [QC_W-1:0] qc;
        logic [3:0]             neg;
        logic [QA_W-1:0]        mag;
        for (int i = 0; i < 4; i++)
        begin
            qc           = signed'(pay8[i*QC_W +: QC_W]);
            neg[i]       = qc[QC_W-1];
            mag          = neg[i] ? QA_W'(-qc) : QA_W'(qc);
            num8_next[i] = N2_W'(mag) << FRAC_BITS;
        end
        pay8_next = {(nrm[0] == '0), neg, pay8[4*QC_W +: 2]};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num8_reg <= num8_next;
            den8_reg <= nrm[0];
            pay8_reg <= pay8_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else if (ce)
        begin
            v8_reg <= v8;
        end
    end

    // ------------------------------------------------------------------
    // Normalising quotients
    // ------------------------------------------------------------------
    logic             v9;
    logic [Q2_W-1:0]  quo2 [4];
    logic [P8_W-1:0]  pay9;

    rmq_div_pipe #(
        .NUM_W (N2_W),
        .DEN_W (RW2),
        .QW    (Q2_W),
        .LANES (4),
        .PW    (P8_W)
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v8_reg),
        .num       (num8_reg),
        .den       (den8_reg),
        .in_pay    (pay8_reg),
        .out_valid (v9),
        .quo       (quo2),
        .out_pay   (pay9)
    );

    // ------------------------------------------------------------------
    // Output register: signs, saturation, degenerate case
    // ------------------------------------------------------------------
    logic [4*ELEM_W-1:0] tdata_next;
    logic [4*ELEM_W-1:0] tdata_reg;
    logic [2:0]          tuser_reg;
    logic                tvalid_reg;

    always_comb
    begin
        logic [3:0]        neg;
        logic              nz;
        logic [QY-1:0]     qy;
        logic [ELEM_W-1:0] q16;
        neg = pay9[2 +: 4];
        nz  = pay9[6];
        for (int i = 0; i < 4; i++)
        begin
            qy = QY'(quo2[i]);
            if (nz)
            begin
                q16 = '0;
            end
            else if (neg[i])
            begin
                q16 = (qy >= QY'(32768)) ? 16'h8000 : ELEM_W'(-qy[ELEM_W-1:0]);
            end
            else
            begin
                q16 = (qy > QY'(32767)) ? 16'h7FFF : qy[ELEM_W-1:0];
            end
            tdata_next[i*ELEM_W +: ELEM_W] = q16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= {pay9[6], pay9[1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (ce)
        begin
            tvalid_reg <= v9;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

@@ rtl/rmq_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, with side data.
`timescale 1ns / 1ps

module rmq_sqrt_pipe #(
    parameter int XW    = 32,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [XW-1:0]       x [LANES],
    input  logic [PW-1:0]       in_pay,
    output logic                out_valid,
    output logic [XW/2-1:0]     root [LANES],
    output logic [PW-1:0]       out_pay
);

    localparam int RW = XW / 2;

    logic [XW-1:0] rem_reg [RW][LANES];
    logic [RW-1:0] res_reg [RW][LANES];
    logic [PW-1:0] pay_reg [RW];
    logic          vld_reg [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int K = RW - 1 - s;

        logic [XW-1:0] rem_src [LANES];
        logic [RW-1:0] res_src [LANES];
        logic [PW-1:0] pay_src;
        logic          vld_src;

        // Take the previous stage, or the inputs at the head
        if (s == 0) begin : g_src_in
            assign vld_src = in_valid;
            assign pay_src = in_pay;
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign rem_src[l] = x[l];
                assign res_src[l] = '0;
            end
        end else begin : g_src_reg
            assign vld_src = vld_reg[s-1];
            assign pay_src = pay_reg[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign rem_src[l] = rem_reg[s-1][l];
                assign res_src[l] = res_reg[s-1][l];
            end
        end

        // Try one root bit: keep it if the remainder covers the trial term
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [XW:0]   trial;
            logic          take;
            logic [XW-1:0] rem_next;
            logic [RW-1:0] res_next;

            assign trial    = ((XW+1)'(res_src[l]) << (K + 1)) + ((XW+1)'(1) << (2 * K));
            assign take     = {1'b0, rem_src[l]} >= trial;
            assign rem_next = take ? (rem_src[l] - trial[XW-1:0]) : rem_src[l];
            assign res_next = take ? (res_src[l] | (RW'(1) << K)) : res_src[l];

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[s][l] <= rem_next;
                    res_reg[s][l] <= res_next;
                end
            end
        end

        // Advance side data
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                pay_reg[s] <= pay_src;
            end
        end

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[s] <= vld_src;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign root[l] = res_reg[RW-1][l];
    end

endmodule

@@ rtl/rmq_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps

module rmq_div_pipe #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QW    = 16,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    num [LANES],
    input  logic [DEN_W-1:0]    den,
    input  logic [PW-1:0]       in_pay,
    output logic                out_valid,
    output logic [QW-1:0]       quo [LANES],
    output logic [PW-1:0]       out_pay
);

    localparam int EW = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int SW = NUM_W + DEN_W + QW;

    logic [NUM_W-1:0] rem_reg [QW][LANES];
    logic [QW-1:0]    quo_reg [QW][LANES];
    logic [DEN_W-1:0] den_reg [QW];
    logic [PW-1:0]    pay_reg [QW];
    logic             vld_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int K = QW - 1 - s;

        logic [NUM_W-1:0] rem_src [LANES];
        logic [QW-1:0]    quo_src [LANES];
        logic [DEN_W-1:0] den_src;
        logic [PW-1:0]    pay_src;
        logic             vld_src;
        logic [SW-1:0]    den_sh;

        // Take the previous stage, or the inputs at the head
        if (s == 0) begin : g_src_in
            assign vld_src = in_valid;
            assign pay_src = in_pay;
            assign den_src = den;
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign rem_src[l] = num[l];
                assign quo_src[l] = '0;
            end
        end else begin : g_src_reg
            assign vld_src = vld_reg[s-1];
            assign pay_src = pay_reg[s-1];
            assign den_src = den_reg[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane_src
                assign rem_src[l] = rem_reg[s-1][l];
                assign quo_src[l] = quo_reg[s-1][l];
            end
        end

        assign den_sh = SW'(den_src) << K;

        // Subtract the shifted divisor where it fits
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [EW-1:0]    rem_hi;
            logic             take;
            logic [NUM_W-1:0] rem_next;
            logic [QW-1:0]    quo_next;

            assign rem_hi   = EW'(rem_src[l] >> K);
            assign take     = rem_hi >= EW'(den_src);
            assign rem_next = take ? (rem_src[l] - den_sh[NUM_W-1:0]) : rem_src[l];
            assign quo_next = take ? (quo_src[l] | (QW'(1) << K)) : quo_src[l];

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[s][l] <= rem_next;
                    quo_reg[s][l] <= quo_next;
                end
            end
        end

        // Advance divisor and side data
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[s] <= den_src;
                pay_reg[s] <= pay_src;
            end
        end

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[s] <= vld_src;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quo[l] = quo_reg[QW-1][l];
    end

endmodule
